FILE: hw/rtl/sha256_stream_hasher_core_macros.svh
// Assertion macros for the hasher RTL.
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha assertion failed");

`endif

FILE: hw/rtl/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [6:0] LEN_POS = 7'd56;
  localparam logic [6:0] LAST_BYTE = 7'd63;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       has_end;
  } item_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: hw/rtl/sha_front.sv
// Input side: takes transactions, drops empty ones, queues the rest.
module sha_front #(
  parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_byte_valid,
  input  logic           in_end_of_message,
  output sha_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sha_pkg::item_t q_mem [QUEUE_DEPTH];
  logic [PW-1:0] rd_ptr_r, wr_ptr_r;
  logic [CW-1:0] cnt_r;
  logic push;

  assign in_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign push = in_valid && in_ready && (in_byte_valid || in_end_of_message);
  assign q_valid = (cnt_r != '0);
  assign q_item = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{data: in_data_byte, has_byte: in_byte_valid,
                           has_end: in_end_of_message};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/sha_engine.sv
// Back end: block assembly, padding, 64-round compression and digest output.
`include "sha256_stream_hasher_core_macros.svh"
module sha_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  sha_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_digest_word,
  output logic [2:0]     out_word_index,
  output logic           out_last_word
);

  typedef enum logic [2:0] {S_IDLE, S_ROUND, S_ADD, S_PAD, S_LEN, S_OUT} state_t;
  typedef enum logic [1:0] {A_IDLE, A_PAD, A_LEN, A_OUT} after_t;

  state_t      state_r;
  after_t      after_r;
  logic [6:0]  fill_r;
  logic [60:0] len_r;
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic [31:0] blk_r [16];
  logic [31:0] hash_r [8];
  logic [31:0] wv_r [8];
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  logic [31:0] t1, t2, w_new;
  logic [63:0] len_bits;
  logic [31:0] pad_blk [16];
  logic [5:0]  pos;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index = out_idx_r;
  assign out_last_word = out_last_r;
  assign len_bits = {len_r, 3'b000};

  always_comb begin
    t1 = wv_r[7] + sha_pkg::big_sig1(wv_r[4]) +
         ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6])) + sha_pkg::ROUND_K[rnd_r] + blk_r[0];
    t2 = sha_pkg::big_sig0(wv_r[0]) +
         ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
    w_new = sha_pkg::small_sig1(blk_r[14]) + blk_r[9] +
            sha_pkg::small_sig0(blk_r[1]) + blk_r[0];
  end

  always_comb begin
    pos = '0;
    for (int w = 0; w < 16; w++) begin
      for (int l = 0; l < 4; l++) begin
        pos = 6'(w * 4 + l);
        if (pos < fill_r[5:0]) begin
          pad_blk[w][(3 - l) * 8 +: 8] = blk_r[w][(3 - l) * 8 +: 8];
        end else if (pos == fill_r[5:0]) begin
          pad_blk[w][(3 - l) * 8 +: 8] = sha_pkg::PAD_MARK;
        end else begin
          pad_blk[w][(3 - l) * 8 +: 8] = 8'h00;
        end
      end
    end
    if (fill_r < sha_pkg::LEN_POS) begin
      pad_blk[14] = len_bits[63:32];
      pad_blk[15] = len_bits[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= A_IDLE;
      fill_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha_pkg::INIT_H[i];
      end
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.has_byte) begin
              blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= q_item.data;
              len_r <= len_r + 61'd1;
              if (fill_r == sha_pkg::LAST_BYTE) begin
                fill_r <= '0;
                for (int i = 0; i < 8; i++) begin
                  wv_r[i] <= hash_r[i];
                end
                rnd_r <= '0;
                after_r <= q_item.has_end ? A_PAD : A_IDLE;
                state_r <= S_ROUND;
              end else begin
                fill_r <= fill_r + 7'd1;
                if (q_item.has_end) begin
                  state_r <= S_PAD;
                end
              end
            end else begin
              state_r <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          wv_r[7] <= wv_r[6];
          wv_r[6] <= wv_r[5];
          wv_r[5] <= wv_r[4];
          wv_r[4] <= wv_r[3] + t1;
          wv_r[3] <= wv_r[2];
          wv_r[2] <= wv_r[1];
          wv_r[1] <= wv_r[0];
          wv_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            blk_r[i] <= blk_r[i + 1];
          end
          blk_r[15] <= w_new;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_r[i] <= hash_r[i] + wv_r[i];
          end
          idx_r <= '0;
          unique case (after_r)
            A_IDLE: state_r <= S_IDLE;
            A_PAD:  state_r <= S_PAD;
            A_LEN:  state_r <= S_LEN;
            A_OUT:  state_r <= S_OUT;
            default: state_r <= S_IDLE;
          endcase
        end
        S_PAD: begin
          blk_r <= pad_blk;
          fill_r <= '0;
          for (int i = 0; i < 8; i++) begin
            wv_r[i] <= hash_r[i];
          end
          rnd_r <= '0;
          after_r <= (fill_r < sha_pkg::LEN_POS) ? A_OUT : A_LEN;
          state_r <= S_ROUND;
        end
        S_LEN: begin
          for (int i = 0; i < 14; i++) begin
            blk_r[i] <= '0;
          end
          blk_r[14] <= len_bits[63:32];
          blk_r[15] <= len_bits[31:0];
          for (int i = 0; i < 8; i++) begin
            wv_r[i] <= hash_r[i];
          end
          rnd_r <= '0;
          after_r <= A_OUT;
          state_r <= S_ROUND;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_word_r <= hash_r[0];
            out_idx_r <= idx_r;
            out_last_r <= (idx_r == 3'd7);
            for (int i = 0; i < 7; i++) begin
              hash_r[i] <= hash_r[i + 1];
            end
            hash_r[7] <= sha_pkg::INIT_H[idx_r];
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              fill_r <= '0;
              len_r <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_fill_range, 1'b1, fill_r < 7'd64)
  `SHA_ASSERT_IMP(a_pop_idle, q_pop, state_r == S_IDLE)
  `SHA_ASSERT_NXT(a_round_end, state_r == S_ROUND && rnd_r == 6'd63, state_r == S_ADD)
  `SHA_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(state_r == S_OUT))

endmodule

FILE: hw/rtl/sha256_stream_hasher_core.sv
// Compression runs one round per cycle on a single round unit.
// The output drains one word per cycle while out_ready is high.
// A small input queue keeps accepting transactions while a block is compressed, until full.
// Synchronous active-low reset clears the queue, fill, length, output and loads the initial hash.
// Top level of the SHA-256 stream hasher.
module sha256_stream_hasher_core #(
  parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_pkg::item_t q_item;
  logic q_valid, q_pop;

  sha_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_byte_valid(in_byte_valid),
    .in_end_of_message(in_end_of_message),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  sha_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the SHA-256 stream hasher core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       has_end;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher_core dut (.*);

  always #5 clk = ~clk;

  byte_item_t  pending_items[$];
  digest_out_t digest_words[$];
  int          errors = 0;
  int          send_idle_pct = 17;
  int          recv_idle_pct = 63;
  int          hold_off = 0;
  logic        stall_req = 1'b0;
  logic        stall_started = 1'b0;

  logic [31:0] hash_st[8];
  logic [7:0]  blk[64];
  int          fill;
  logic [60:0] msg_len;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_block();
    logic [31:0] w[16];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 0; j < 8; j++) v[j] = hash_st[j];
    for (int j = 0; j < 64; j++) begin
      if (j >= 16) begin
        s0 = ror(w[(j-15)&15], 7) ^ ror(w[(j-15)&15], 18) ^ (w[(j-15)&15] >> 3);
        s1 = ror(w[(j-2)&15], 17) ^ ror(w[(j-2)&15], 19) ^ (w[(j-2)&15] >> 10);
        w[j&15] = s1 + w[(j-7)&15] + s0 + w[j&15];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[j] + w[j&15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_st[j] += v[j];
  endtask

  task automatic hash_init();
    for (int j = 0; j < 8; j++) hash_st[j] = sha_pkg::INIT_H[j];
    fill = 0;
    msg_len = '0;
  endtask

  task automatic absorb_item(input byte_item_t it);
    logic [63:0] bits;
    digest_out_t d;
    if (it.has_byte) begin
      blk[fill] = it.data;
      fill++;
      msg_len++;
      if (fill == 64) begin
        hash_block();
        fill = 0;
      end
    end
    if (!it.has_end) return;
    blk[fill] = sha_pkg::PAD_MARK;
    fill++;
    if (fill > 56) begin
      while (fill < 64) blk[fill++] = 8'h00;
      hash_block();
      fill = 0;
    end
    while (fill < 56) blk[fill++] = 8'h00;
    bits = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    hash_block();
    for (int i = 0; i < 8; i++) begin
      d.word = hash_st[i];
      d.idx = i[2:0];
      d.last = (i == 7);
      digest_words.push_back(d);
    end
    hash_init();
  endtask

  task automatic push_item(input logic [7:0] b, input logic hb, input logic he);
    byte_item_t it;
    it.data = b;
    it.has_byte = hb;
    it.has_end = he;
    pending_items.push_back(it);
  endtask

  task automatic push_message(input int len, input logic end_with_byte);
    for (int i = 0; i < len - 1; i++) push_item(8'($urandom), 1'b1, 1'b0);
    if (len > 0) push_item(8'($urandom), 1'b1, end_with_byte);
    if (len == 0 || !end_with_byte) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_item_t it;
          it = pending_items.pop_front();
          absorb_item(it);
          in_valid <= 1'b1;
          in_data_byte <= it.data;
          in_byte_valid <= it.has_byte;
          in_end_of_message <= it.has_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (stall_req && !stall_started) begin
      stall_started <= 1'b1;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_words.size() == 0) begin
        $error("unexpected transaction: word=%h idx=%0d", out_digest_word, out_word_index);
        errors++;
      end else begin
        digest_out_t e;
        e = digest_words.pop_front();
        if (out_digest_word !== e.word) begin
          $error("digest_word expected %h actual %h", e.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== e.idx) begin
          $error("word_index expected %0d actual %0d", e.idx, out_word_index);
          errors++;
        end
        if (out_last_word !== e.last) begin
          $error("last_word expected %0d actual %0d", e.last, out_last_word);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || digest_words.size() > 0) @(posedge clk);
  endtask

  initial begin
    hash_init();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty, idle-only, two pad blocks, full block with end
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h55, 1'b0, 1'b1);
    push_message(3, 1'b1);
    push_message(56, 1'b0);
    push_message(64, 1'b1);
    wait_drained();

    // receiver stalls long while sender keeps feeding
    stall_req = 1'b1;
    push_message(20, 1'b1);
    push_message(10, 1'b0);
    push_message(0, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 63;
        recv_idle_pct = 17;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int m = 0; m < 4; m++) begin
        if ($urandom_range(9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
        if ($urandom_range(9) == 0) push_message(0, 1'b0);
        else push_message($urandom_range(8), 1'($urandom_range(1)));
      end
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[sha256_stream_hasher_core] OK");
    else $display("[sha256_stream_hasher_core] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[sha256_stream_hasher_core] ERROR");
    $finish;
  end
endmodule
